### rtl/dsr_pkg.sv
// Shared constants, types, scale function and root-step function for the decimal square root block.
package dsr_pkg;

    localparam int RAD_W        = 32;  // radicand width
    localparam int ROOT_W       = 17;  // integer_root width
    localparam int SCALED_W     = 30;  // scaled_root width
    localparam int DIG_W        = 3;   // decimal_digits register width
    localparam int MAX_DIGITS   = 4;
    localparam logic [DIG_W-1:0] DIGITS_RESET = 3'd3;
    localparam int SCALE_W      = 27;  // holds 100^MAX_DIGITS
    localparam int SQ_W         = 58;  // widest scaled radicand
    localparam int ROOT_STEPS   = SQ_W / 2;  // one result bit per stage
    localparam int IN_TDATA_W   = 32;
    localparam int OUT_TDATA_W  = 48;

    // Remainder and partial root of one digit-by-digit root lane
    typedef struct packed {
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] res;
    } t_lane;

    // One item in flight through the root pipeline
    typedef struct packed {
        t_lane whole;   // plain radicand
        t_lane scaled;  // radicand times 100^digits
        logic  neg;
    } t_item;

    // Pipeline control shared by all stages
    typedef struct packed {
        logic en;       // all stages advance
    } t_pipe_ctrl;

    // 100^digits, digit counts above the maximum saturate
    function automatic logic [SCALE_W-1:0] scale_for(input logic [DIG_W-1:0] digits);
        logic [SCALE_W-1:0] s;
        unique case (digits)
            3'd0:    s = SCALE_W'(1);
            3'd1:    s = SCALE_W'(100);
            3'd2:    s = SCALE_W'(10000);
            3'd3:    s = SCALE_W'(1000000);
            default: s = SCALE_W'(100000000);
        endcase
        return s;
    endfunction

    // One restoring root step; stage k tests bit 4^(ROOT_STEPS-1-k)
    function automatic t_lane root_step(input t_lane a, input int k);
        logic [SQ_W-1:0] bit_v;
        logic [SQ_W:0]   trial;
        t_lane           r;
        bit_v = SQ_W'(1) << (2 * (ROOT_STEPS - 1 - k));
        trial = {1'b0, a.res} + {1'b0, bit_v};
        if ({1'b0, a.rem} >= trial) begin
            r.rem = a.rem - trial[SQ_W-1:0];
            r.res = (a.res >> 1) + bit_v;
        end else begin
            r.rem = a.rem;
            r.res = a.res >> 1;
        end
        return r;
    endfunction

endpackage

### rtl/dsr_scale.sv
// Entry stage: sign check and scaling of the radicand by 100^digits.
module dsr_scale
    import dsr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_pipe_ctrl       i_ctrl,
    input  logic             i_valid,
    input  logic [RAD_W-1:0] i_radicand,
    input  logic [DIG_W-1:0] i_digits,
    output logic             o_valid,
    output t_item            o_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    // scaled radicand: 31-bit magnitude times 27-bit scale fits SQ_W
    always_comb begin
        n_item.neg        = i_radicand[RAD_W-1];
        n_item.whole.rem  = SQ_W'(i_radicand[RAD_W-2:0]);
        n_item.whole.res  = '0;
        n_item.scaled.rem = SQ_W'(i_radicand[RAD_W-2:0]) * SQ_W'(scale_for(i_digits));
        n_item.scaled.res = '0;
    end

    // valid under reset, payload on advance only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### rtl/dsr_root_pipe.sv
// Root pipeline: one result bit per stage for both the plain and scaled lanes.
module dsr_root_pipe
    import dsr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_pipe_ctrl i_ctrl,
    input  logic       i_valid,
    input  t_item      i_item,
    output logic       o_valid,
    output t_item      o_item
);

    logic  r_valid [ROOT_STEPS];
    t_item r_item  [ROOT_STEPS];

    for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_stage
        t_item n_item;
        logic  n_valid;
        t_item src;

        // stage input: pipeline entry or previous stage
        if (k == 0) begin : g_first
            assign src     = i_item;
            assign n_valid = i_valid;
        end else begin : g_next
            assign src     = r_item[k-1];
            assign n_valid = r_valid[k-1];
        end

        always_comb begin
            n_item.neg    = src.neg;
            n_item.whole  = root_step(src.whole, k);
            n_item.scaled = root_step(src.scaled, k);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_ctrl.en) begin
                r_valid[k] <= n_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctrl.en) begin
                r_item[k] <= n_item;
            end
        end
    end

    assign o_valid = r_valid[ROOT_STEPS-1];
    assign o_item  = r_item[ROOT_STEPS-1];

endmodule

### rtl/decimal_square_root_top.sv
// Items pass the entry stage, then 29 root stages; each root stage yields one bit of the 29-bit root
// of a 58-bit value. Throughput: one item per cycle while backpressure does not stall the pipeline.
// Backpressure stalls every stage at once; nothing is dropped or repeated.
// Reset (synchronous, active low) clears all valid bits and sets decimal_digits to 3.
// The digit count in effect when an item is accepted applies to that item.
module decimal_square_root_top
    import dsr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration
    input  logic                   i_cfg_we,
    input  logic [DIG_W-1:0]       i_cfg_wdata,    // decimal_digits
    // input stream
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,      // [31:0] radicand
    // output stream
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,      // [16:0] integer_root, [46:17] scaled_root
    output logic                   o_m_tuser       // [0] negative_input
);

    logic [DIG_W-1:0] r_digits;
    t_pipe_ctrl       ctrl;
    logic             scale_valid;
    t_item            scale_item;
    logic             root_valid;
    t_item            root_item;
    logic [ROOT_W-1:0]   int_root;
    logic [SCALED_W-1:0] scaled_root;

    // digit count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digits <= DIGITS_RESET;
        end else if (i_cfg_we) begin
            r_digits <= i_cfg_wdata;
        end
    end

    // whole pipeline moves unless the last stage holds an untaken item
    assign ctrl.en    = !root_valid || i_m_tready;
    assign o_s_tready = ctrl.en;

    dsr_scale u_scale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (ctrl),
        .i_valid    (i_s_tvalid),
        .i_radicand (i_s_tdata[RAD_W-1:0]),
        .i_digits   (r_digits),
        .o_valid    (scale_valid),
        .o_item     (scale_item)
    );

    dsr_root_pipe u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .i_valid (scale_valid),
        .i_item  (scale_item),
        .o_valid (root_valid),
        .o_item  (root_item)
    );

    // negative radicand reads as -1 on both roots
    assign int_root    = root_item.neg ? '1 : {1'b0, root_item.whole.res[ROOT_W-2:0]};
    assign scaled_root = root_item.neg ? '1 : {1'b0, root_item.scaled.res[SCALED_W-2:0]};

    assign o_m_tvalid = root_valid;
    assign o_m_tdata  = {{(OUT_TDATA_W - ROOT_W - SCALED_W){1'b0}}, scaled_root, int_root};
    assign o_m_tuser  = root_item.neg;

endmodule
